// ----- rtl/core/artt_pkg.sv -----
`default_nettype none
package artt_pkg;
   localparam int TableSlots = 8;
   localparam int SlotW = (TableSlots > 1) ? $clog2(TableSlots) : 1;
   localparam int CntW = $clog2(TableSlots + 1);

   typedef enum logic [1:0] {
      CMD_ENQ  = 2'd0,
      CMD_ACK  = 2'd1,
      CMD_TICK = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_QUEUED   = 3'd0,
      KIND_FULL     = 3'd1,
      KIND_ACKED    = 3'd2,
      KIND_UNMATCH  = 3'd3,
      KIND_RETX     = 3'd4,
      KIND_FALLBACK = 3'd5,
      KIND_TICKDONE = 3'd6
   } kind_type;

   localparam logic CSR_BASE_TIMEOUT = 1'b0;
   localparam logic CSR_MAX_RETRIES  = 1'b1;

   // one command as it travels along the cell row
   typedef struct packed {
      logic                  act;     // cell at this position acts on the command
      logic [1:0]            cmd;
      logic [31:0]           src_id;
      logic [15:0]           pkt_id;
      logic [31:0]           now_ms;
      logic [15:0]           id_base;
      logic [3:0]            tx_free;
      logic [15:0]           base_to;
      logic [3:0]            max_retries;
      logic                  done;    // enqueue or ack already served, or a tick's last slot already acted
      logic [3:0]            pushed;
      logic [3:0]            used;
   } token_type;

   // what a cell reports when it acts
   typedef struct packed {
      logic       hit;
      logic [2:0] kind;
      logic [15:0] fresh_pkt_id;
      logic       push_ok;
      logic       valid_after;
   } cell_ev_type;
endpackage
`default_nettype wire

// ----- rtl/core/artt_if.sv -----
`default_nettype none
interface artt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] src_id;
   logic [15:0] pkt_id;
   logic [31:0] now_ms;
   logic [31:0] id_base;
   logic [3:0]  tx_free;
   modport source (output valid, cmd, src_id, pkt_id, now_ms, id_base, tx_free,
                   input ready);
   modport sink (input valid, cmd, src_id, pkt_id, now_ms, id_base, tx_free,
                 output ready);
endinterface

interface artt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [2:0]  slot;
   logic [15:0] fresh_pkt_id;
   logic        push_ok;
   logic [3:0]  pushed_total;
   logic [3:0]  ids_used;
   logic [3:0]  live_count;
   logic        last;
   modport source (output valid, kind, slot, fresh_pkt_id, push_ok, pushed_total,
                   ids_used, live_count, last, input ready);
   modport sink (input valid, kind, slot, fresh_pkt_id, push_ok, pushed_total,
                 ids_used, live_count, last, output ready);
endinterface

interface artt_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ack_retry_timer_table_top.sv -----
`default_nettype none
// channel | dir | handshake   | carries
// req     | in  | valid/ready | cmd, src_id, pkt_id, now_ms, id_base, tx_free
// rsp     | out | valid/ready | kind, slot, fresh_pkt_id, push_ok, totals, live, last
// csr     | in  | valid/ready | index (0 base timeout, 1 max retries), data
//
// A request walks the row of slot cells, one cell a cycle while no held result
// stalls it; the walking token is handed from cell to cell so that at most
// one cell acts per cycle. A request is accepted and then walks the slots in
// order; a tick whose last slot expires takes a closing step for its final
// result. The walk holds while the result register is full and not taken.
// Reset clears the valid bits and the controller; payload needs no reset.
// Unused command code 3 is dropped without a result.
module ack_retry_timer_table_top (
   input wire logic clock,
   input wire logic reset,
   artt_req_if.sink   req,
   artt_rsp_if.source rsp,
   artt_csr_if.sink   csr
);
   import artt_pkg::*;

   logic [15:0] base_to_ff;
   logic [3:0]  max_ret_ff;
   logic        busy_ff;
   logic [SlotW-1:0] pos_ff;
   token_type   tok_ff, tok_in;
   token_type   tok_o [TableSlots];
   cell_ev_type ev [TableSlots];
   logic [TableSlots-1:0] vq;
   logic        rsp_v_ff;
   logic        stall, fin;
   cell_ev_type ev_sel;
   token_type   tok_sel;
   logic [CntW-1:0] live_now;
   logic [3:0]  live_after;

   assign csr.ready = 1'b1;
   assign req.ready = !busy_ff;
   assign stall = rsp_v_ff && !rsp.ready;
   assign fin   = (pos_ff == SlotW'(TableSlots - 1));

   // hold every cell idle except the one at pos, and only while not stalled
   genvar g;
   generate
      for (g = 0; g < TableSlots; g++) begin : g_cell
         token_type t;
         always_comb begin
            t = tok_ff;
            t.act = busy_ff && !stall && (pos_ff == SlotW'(g));
         end
         artt_cell u_cell (
            .clock  (clock),
            .reset  (reset),
            .tok_in (t),
            .tok_out(tok_o[g]),
            .ev     (ev[g]),
            .valid_q(vq[g])
         );
      end
   endgenerate

   assign ev_sel  = ev[pos_ff];
   assign tok_sel = tok_o[pos_ff];

   always_comb begin
      live_now = '0;
      for (int i = 0; i < TableSlots; i++) begin
         if (SlotW'(i) == pos_ff) live_now = live_now + CntW'(ev[i].valid_after);
         else live_now = live_now + CntW'(vq[i]);
      end
      live_after = 4'(live_now);
   end

   always_comb begin
      tok_in = tok_ff;
      if (busy_ff && !stall) begin
         tok_in = tok_sel;
         // last slot has acted; keep it from acting again on the closing cycle
         if (ev_sel.hit && fin) tok_in.done = 1'b1;
      end
      if (req.valid && !busy_ff) begin
         tok_in.act         = 1'b0;
         tok_in.cmd         = req.cmd;
         tok_in.src_id      = req.src_id;
         tok_in.pkt_id      = req.pkt_id;
         tok_in.now_ms      = req.now_ms;
         tok_in.id_base     = req.id_base[15:0];
         tok_in.tx_free     = req.tx_free;
         tok_in.base_to     = base_to_ff;
         tok_in.max_retries = max_ret_ff;
         tok_in.done        = 1'b0;
         tok_in.pushed      = 4'd0;
         tok_in.used        = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      if (reset) begin
         base_to_ff <= 16'd1000;
         max_ret_ff <= 4'd3;
         busy_ff    <= 1'b0;
         pos_ff     <= '0;
         rsp_v_ff   <= 1'b0;
      end else begin
         if (csr.valid) begin
            unique case (csr.index)
               CSR_BASE_TIMEOUT: base_to_ff <= csr.data;
               CSR_MAX_RETRIES:  max_ret_ff <= csr.data[3:0];
            endcase
         end
         // load a new result, or drop the held one once it is taken
         if (busy_ff && !stall && (ev_sel.hit || fin)) rsp_v_ff <= 1'b1;
         else if (rsp.ready) rsp_v_ff <= 1'b0;
         if (req.valid && !busy_ff) begin
            busy_ff <= (cmd_type'(req.cmd) != CMD_NONE);
            pos_ff  <= '0;
         end else if (busy_ff && !stall) begin
            // advance; emit a slot result or, at the end, the closing one
            if (ev_sel.hit) begin
               rsp.kind         <= ev_sel.kind;
               rsp.slot         <= 3'(pos_ff);
               rsp.fresh_pkt_id <= ev_sel.fresh_pkt_id;
               rsp.push_ok      <= ev_sel.push_ok;
               rsp.pushed_total <= tok_sel.pushed;
               rsp.ids_used     <= tok_sel.used;
               rsp.live_count   <= live_after;
               rsp.last         <= (cmd_type'(tok_ff.cmd) != CMD_TICK);
               if (cmd_type'(tok_ff.cmd) != CMD_TICK) busy_ff <= 1'b0;
            end else if (fin) begin
               rsp.slot         <= 3'd0;
               rsp.fresh_pkt_id <= 16'd0;
               rsp.push_ok      <= 1'b0;
               rsp.live_count   <= live_after;
               rsp.last         <= 1'b1;
               unique case (cmd_type'(tok_ff.cmd))
                  CMD_ENQ:  rsp.kind <= KIND_FULL;
                  CMD_ACK:  rsp.kind <= KIND_UNMATCH;
                  default:  rsp.kind <= KIND_TICKDONE;
               endcase
               rsp.pushed_total <= (cmd_type'(tok_ff.cmd) == CMD_TICK) ? tok_sel.pushed : 4'd0;
               rsp.ids_used     <= (cmd_type'(tok_ff.cmd) == CMD_TICK) ? tok_sel.used : 4'd0;
               busy_ff <= 1'b0;
            end
            if (!(ev_sel.hit && cmd_type'(tok_ff.cmd) == CMD_TICK && fin))
               pos_ff <= fin ? pos_ff : pos_ff + SlotW'(1);
         end
      end
   end

   assign rsp.valid = rsp_v_ff;
endmodule
`default_nettype wire

// ----- rtl/core/artt_cell.sv -----
`default_nettype none
module artt_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire artt_pkg::token_type tok_in,
   output artt_pkg::token_type      tok_out,
   output artt_pkg::cell_ev_type    ev,
   output logic                     valid_q
);
   import artt_pkg::*;

   logic        valid_ff, valid_in;
   logic [31:0] acker_ff, acker_in;
   logic [15:0] pid_ff, pid_in;
   logic [31:0] dl_ff, dl_in;
   logic [31:0] ivl_ff, ivl_in;
   logic [3:0]  ret_ff, ret_in;
   logic [31:0] diff, ivl2;
   logic [3:0]  used1;
   logic        okp;

   assign valid_q = valid_ff;
   assign diff  = tok_in.now_ms - dl_ff;
   assign ivl2  = {ivl_ff[30:0], 1'b0};
   assign used1 = tok_in.used + 4'd1;
   assign okp   = (tok_in.pushed < tok_in.tx_free);

   always_comb begin
      valid_in = valid_ff;
      acker_in = acker_ff;
      pid_in   = pid_ff;
      dl_in    = dl_ff;
      ivl_in   = ivl_ff;
      ret_in   = ret_ff;
      tok_out  = tok_in;
      ev       = '0;
      if (tok_in.act && !tok_in.done) begin
         unique case (cmd_type'(tok_in.cmd))
            CMD_ENQ: begin
               if (!valid_ff) begin
                  valid_in = 1'b1;
                  acker_in = tok_in.src_id;
                  pid_in   = tok_in.pkt_id;
                  dl_in    = tok_in.now_ms + {16'd0, tok_in.base_to};
                  ivl_in   = {16'd0, tok_in.base_to};
                  ret_in   = tok_in.max_retries;
                  tok_out.done = 1'b1;
                  ev.hit  = 1'b1;
                  ev.kind = KIND_QUEUED;
               end
            end
            CMD_ACK: begin
               if (valid_ff && acker_ff == tok_in.src_id && pid_ff == tok_in.pkt_id) begin
                  valid_in = 1'b0;
                  tok_out.done = 1'b1;
                  ev.hit  = 1'b1;
                  ev.kind = KIND_ACKED;
               end
            end
            CMD_TICK: begin
               if (valid_ff && !diff[31]) begin
                  tok_out.used   = used1;
                  tok_out.pushed = tok_in.pushed + {3'd0, okp};
                  ev.hit          = 1'b1;
                  ev.fresh_pkt_id = tok_in.id_base + {12'd0, used1};
                  ev.push_ok      = okp;
                  if (ret_ff != 4'd0) begin
                     pid_in = tok_in.id_base + {12'd0, used1};
                     ret_in = ret_ff - 4'd1;
                     ivl_in = ivl2;
                     dl_in  = tok_in.now_ms + ivl2;
                     ev.kind = KIND_RETX;
                  end else begin
                     valid_in = 1'b0;
                     ev.kind  = KIND_FALLBACK;
                  end
               end
            end
            default: ;
         endcase
      end
      ev.valid_after = valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      acker_ff <= acker_in;
      pid_ff   <= pid_in;
      dl_ff    <= dl_in;
      ivl_ff   <= ivl_in;
      ret_ff   <= ret_in;
   end
endmodule
`default_nettype wire
